/* rtl/zfl_pkg.sv */
// zfl_pkg: breakpoint table, per-segment constants and word types for the
// zoom to focal length pipeline. No dependencies; used by every rtl file.

package zfl_pkg;

    localparam int unsigned TABLE_POINTS = 7;
    localparam int unsigned SEGS         = TABLE_POINTS - 1;
    localparam int unsigned SEG_W        = $clog2(SEGS);

    localparam int unsigned POS_W   = 8;
    localparam int unsigned FL_W    = 17;
    localparam int unsigned EFL_W   = 20;
    localparam int unsigned RATIO_W = 8;
    localparam int unsigned CROP_W  = 14;

    localparam logic [CROP_W-1:0] CROP_RESET = 14'd5600;

    localparam logic [POS_W-1:0] BP_POS [TABLE_POINTS] = '{
        8'd0, 8'd11, 8'd41, 8'd64, 8'd86, 8'd105, 8'd128
    };
    localparam logic [FL_W-1:0] BP_FL [TABLE_POINTS] = '{
        17'd5000, 17'd6190, 17'd12610, 17'd25240, 17'd45470, 17'd65880, 17'd100000
    };

    // offset within a segment, at most the widest segment span
    localparam int unsigned OFF_W  = 5;
    localparam int unsigned DZ_W   = 5;
    localparam int unsigned DF_W   = 16;
    localparam int unsigned PROD_W = 20;
    localparam int unsigned QUO_W  = 16;

    // reciprocal division by the segment span
    localparam int unsigned DIV_SHIFT = 20;
    localparam int unsigned RECIP_W   = 17;
    localparam logic [RECIP_W-1:0] SEG_RECIP [SEGS] = '{
        17'((1 << DIV_SHIFT) / (BP_POS[1] - BP_POS[0])),
        17'((1 << DIV_SHIFT) / (BP_POS[2] - BP_POS[1])),
        17'((1 << DIV_SHIFT) / (BP_POS[3] - BP_POS[2])),
        17'((1 << DIV_SHIFT) / (BP_POS[4] - BP_POS[3])),
        17'((1 << DIV_SHIFT) / (BP_POS[5] - BP_POS[4])),
        17'((1 << DIV_SHIFT) / (BP_POS[6] - BP_POS[5]))
    };

    // ratio in tenths: fl * 10 / shortest fl == fl / (shortest fl / 10)
    localparam int unsigned RATIO_DIV   = BP_FL[0] / 10;
    localparam int unsigned RATIO_SHIFT = 17;
    localparam logic [8:0]  RATIO_RECIP = 9'((1 << RATIO_SHIFT) / RATIO_DIV);

    // effective focal length: fl * crop / 1000
    localparam int unsigned EFL_DIV     = 1000;
    localparam int unsigned EFL_SHIFT   = 31;
    localparam int unsigned EFL_P_W     = FL_W + CROP_W;
    localparam int unsigned EFL_Q_W     = 22;
    localparam logic [EFL_Q_W-1:0] EFL_RECIP = 22'((64'd1 << EFL_SHIFT) / EFL_DIV);
    localparam logic [EFL_W-1:0]   EFL_MAX   = '1;

    typedef struct packed {
        logic [FL_W-1:0]  base;
        logic [OFF_W-1:0] off;
        logic [SEG_W-1:0] seg;
    } t_seg_word;

    typedef struct packed {
        logic [FL_W-1:0]    fl;
        logic [EFL_W-1:0]   efl;
        logic [RATIO_W-1:0] ratio;
    } t_res_word;

    function automatic logic [DF_W-1:0] seg_df(input logic [SEG_W-1:0] k);
        return DF_W'(BP_FL[int'(k) + 1] - BP_FL[int'(k)]);
    endfunction

    function automatic logic [DZ_W-1:0] seg_dz(input logic [SEG_W-1:0] k);
        return DZ_W'(BP_POS[int'(k) + 1] - BP_POS[int'(k)]);
    endfunction

endpackage

/* rtl/zfl_seg.sv */
// zfl_seg: stage 1, clamp and segment search over the breakpoint table.
// Depends on zfl_pkg.

module zfl_seg import zfl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [POS_W-1:0] i_pos,
    output logic             o_ready,
    output logic             o_valid,
    output t_seg_word        o_word,
    input  logic             i_ready
);

    logic      r_valid;
    t_seg_word r_word;
    t_seg_word n_word;
    logic      en;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        logic [SEG_W-1:0] seg;
        seg = SEG_W'(SEGS - 1);
        for (int k = SEGS - 1; k >= 0; k--) begin
            if (i_pos <= BP_POS[k + 1]) begin
                seg = SEG_W'(k);
            end
        end
        if (i_pos >= BP_POS[TABLE_POINTS - 1]) begin
            n_word.seg  = SEG_W'(SEGS - 1);
            n_word.base = BP_FL[TABLE_POINTS - 1];
            n_word.off  = '0;
        end else begin
            n_word.seg  = seg;
            n_word.base = BP_FL[seg];
            n_word.off  = OFF_W'(i_pos - BP_POS[seg]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_word <= n_word;
        end
    end

endmodule

/* rtl/zfl_div.sv */
// zfl_div: stages 2 to 4, segment product, reciprocal quotient and
// correction, giving the interpolated focal length. Depends on zfl_pkg.

module zfl_div import zfl_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_seg_word       i_word,
    output logic            o_ready,
    output logic            o_valid,
    output logic [FL_W-1:0] o_fl,
    input  logic            i_ready
);

    logic                r2_valid, r3_valid, r4_valid;
    logic                en2, en3, en4;

    logic [PROD_W-1:0]   r2_prod, r3_prod;
    logic [SEG_W-1:0]    r2_seg, r3_seg;
    logic [FL_W-1:0]     r2_base, r3_base;
    logic [QUO_W-1:0]    r3_q;
    logic [FL_W-1:0]     r4_fl;

    logic [PROD_W-1:0]           n2_prod;
    logic [PROD_W+RECIP_W-1:0]   p3;
    logic [QUO_W-1:0]            n3_q;
    logic [QUO_W+DZ_W-1:0]       qdz;
    logic [PROD_W-1:0]           rem;
    logic [QUO_W-1:0]            q_fix;
    logic [FL_W-1:0]             n4_fl;

    assign en4     = !r4_valid || i_ready;
    assign en3     = !r3_valid || en4;
    assign en2     = !r2_valid || en3;
    assign o_ready = en2;
    assign o_valid = r4_valid;
    assign o_fl    = r4_fl;

    always_comb begin
        n2_prod = PROD_W'(i_word.off * seg_df(i_word.seg));
        p3      = r2_prod * SEG_RECIP[r2_seg];
        n3_q    = p3[DIV_SHIFT +: QUO_W];
        qdz     = r3_q * seg_dz(r3_seg);
        rem     = r3_prod - PROD_W'(qdz);
        if (rem >= PROD_W'(seg_dz(r3_seg))) begin
            q_fix = r3_q + 1'b1;
        end else begin
            q_fix = r3_q;
        end
        n4_fl = r3_base + FL_W'(q_fix);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en2) begin
                r2_valid <= i_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
            if (en4) begin
                r4_valid <= r3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_prod <= n2_prod;
            r2_seg  <= i_word.seg;
            r2_base <= i_word.base;
        end
        if (en3) begin
            r3_prod <= r2_prod;
            r3_seg  <= r2_seg;
            r3_base <= r2_base;
            r3_q    <= n3_q;
        end
        if (en4) begin
            r4_fl <= n4_fl;
        end
    end

endmodule

/* rtl/zfl_scale.sv */
// zfl_scale: stages 5 to 7, crop-factor scaling and zoom ratio by
// reciprocal multiplication with correction. Depends on zfl_pkg.

module zfl_scale import zfl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CROP_W-1:0] i_crop,
    input  logic              i_valid,
    input  logic [FL_W-1:0]   i_fl,
    output logic              o_ready,
    output logic              o_valid,
    output t_res_word         o_word,
    input  logic              i_ready
);

    logic                 r5_valid, r6_valid, r7_valid;
    logic                 en5, en6, en7;

    logic [FL_W-1:0]      r5_fl, r6_fl;
    logic [EFL_P_W-1:0]   r5_p, r6_p;
    logic [RATIO_W-1:0]   r5_ratio, r6_ratio;
    logic [EFL_Q_W-1:0]   r6_q;
    t_res_word            r7_word;

    logic [FL_W+8:0]              rp;
    logic [EFL_P_W+EFL_Q_W-1:0]   ep;
    logic [FL_W+9:0]              r500;
    logic [FL_W-1:0]              rrem;
    logic [RATIO_W-1:0]           n6_ratio;
    logic [EFL_Q_W+9:0]           q1000;
    logic [EFL_P_W-1:0]           erem;
    logic [EFL_Q_W-1:0]           q_fix;
    t_res_word                    n7_word;

    assign en7     = !r7_valid || i_ready;
    assign en6     = !r6_valid || en7;
    assign en5     = !r5_valid || en6;
    assign o_ready = en5;
    assign o_valid = r7_valid;
    assign o_word  = r7_word;

    always_comb begin
        rp   = i_fl * RATIO_RECIP;
        ep   = r5_p * EFL_RECIP;
        r500 = r5_ratio * 10'(RATIO_DIV);
        rrem = r5_fl - FL_W'(r500);
        if (rrem >= FL_W'(RATIO_DIV)) begin
            n6_ratio = r5_ratio + 1'b1;
        end else begin
            n6_ratio = r5_ratio;
        end
        q1000 = r6_q * 10'(EFL_DIV);
        erem  = r6_p - EFL_P_W'(q1000);
        if (erem >= EFL_P_W'(EFL_DIV)) begin
            q_fix = r6_q + 1'b1;
        end else begin
            q_fix = r6_q;
        end
        n7_word.fl    = r6_fl;
        n7_word.ratio = r6_ratio;
        if (q_fix > EFL_Q_W'(EFL_MAX)) begin
            n7_word.efl = EFL_MAX;
        end else begin
            n7_word.efl = q_fix[EFL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else begin
            if (en5) begin
                r5_valid <= i_valid;
            end
            if (en6) begin
                r6_valid <= r5_valid;
            end
            if (en7) begin
                r7_valid <= r6_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_fl    <= i_fl;
            r5_p     <= i_fl * i_crop;
            r5_ratio <= rp[RATIO_SHIFT +: RATIO_W];
        end
        if (en6) begin
            r6_fl    <= r5_fl;
            r6_p     <= r5_p;
            r6_ratio <= n6_ratio;
            r6_q     <= ep[EFL_SHIFT +: EFL_Q_W];
        end
        if (en7) begin
            r7_word <= n7_word;
        end
    end

endmodule

/* rtl/zoom_to_focal_length_interp.sv */
// zoom_to_focal_length_interp: top level, crop factor register and the
// seven-stage pipeline. Depends on zfl_pkg, zfl_seg, zfl_div, zfl_scale.
//
// usage
//   input channel: i_valid / o_stall with i_zoom_position; a word is taken
//   at a clock edge with i_valid high and o_stall low
//   output channel: o_valid / i_stall with o_focal_length_um,
//   o_effective_focal_um and o_zoom_ratio_tenths; one result word per
//   input word, in order
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_data, the crop
//   factor times 1000; o_cfg_ready is always high, write only when idle
//   pipeline: seven register stages, in order search, product, reciprocal
//   multiply, correction, crop multiply, reciprocal multiply, correction
//   and saturation; o_valid rises once a word reaches the last stage
//   throughput: one word per cycle while i_stall is low, each stage holds one word
//   stall: a stalled result holds in the output register; each stage
//   still fills while the stage after it is empty, so o_stall rises only
//   once all seven stages hold words
//   reset: pipeline empties, crop factor returns to 5600

module zoom_to_focal_length_interp import zfl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [POS_W-1:0]    i_zoom_position,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [FL_W-1:0]     o_focal_length_um,
    output logic [EFL_W-1:0]    o_effective_focal_um,
    output logic [RATIO_W-1:0]  o_zoom_ratio_tenths,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CROP_W-1:0]   i_cfg_data
);

    logic [CROP_W-1:0] r_crop;
    logic              seg_ready, seg_valid;
    t_seg_word         seg_word;
    logic              div_ready, div_valid;
    logic [FL_W-1:0]   div_fl;
    logic              scl_ready;
    t_res_word         res_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crop <= CROP_RESET;
        end else if (i_cfg_valid) begin
            r_crop <= i_cfg_data;
        end
    end

    assign o_stall = !seg_ready;

    zfl_seg u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_pos   (i_zoom_position),
        .o_ready (seg_ready),
        .o_valid (seg_valid),
        .o_word  (seg_word),
        .i_ready (div_ready)
    );

    zfl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seg_valid),
        .i_word  (seg_word),
        .o_ready (div_ready),
        .o_valid (div_valid),
        .o_fl    (div_fl),
        .i_ready (scl_ready)
    );

    zfl_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_crop  (r_crop),
        .i_valid (div_valid),
        .i_fl    (div_fl),
        .o_ready (scl_ready),
        .o_valid (o_valid),
        .o_word  (res_word),
        .i_ready (!i_stall)
    );

    assign o_focal_length_um    = res_word.fl;
    assign o_effective_focal_um = res_word.efl;
    assign o_zoom_ratio_tenths  = res_word.ratio;

endmodule
